// ===== sv/wsm_pkg.sv =====
// Package for the weighted signature matcher: signature text, lengths, weights,
// per-position compare function, verdict codes and the result struct.
// No dependencies.
package wsm_pkg;

    localparam int SIG_COUNT = 16;
    localparam int HIST_LEN  = 14;
    localparam int SIG_MAX   = 15;
    localparam int POS_W     = 4;
    localparam int BYTES_W   = 12;
    localparam int SUM_W     = 10;
    localparam int GSUM_W    = 8;
    localparam int GCNT_W    = 3;
    localparam int CNT_W     = 5;
    localparam int GROUPS    = 4;
    localparam int GROUP_SZ  = SIG_COUNT / GROUPS;

    localparam logic [BYTES_W-1:0] MAX_BYTES = 12'd4095;

    localparam logic [7:0] CFG_SCORE_CAP   = 8'd0;
    localparam logic [7:0] CFG_SUSP_LIMIT  = 8'd1;
    localparam logic [7:0] RESET_SCORE_CAP = 8'd100;
    localparam logic [7:0] RESET_SUSP_LIM  = 8'd25;

    // last character of each signature sits in the lowest byte
    localparam logic [8*SIG_MAX-1:0] SIG_TEXT [SIG_COUNT] = '{
        "' or ",
        "or 1=1",
        "' or '1'='1",
        "--",
        "drop table",
        "union select",
        "delete from",
        "<script",
        "</script>",
        "onerror=",
        "onload=",
        "onclick=",
        "javascript:",
        "<iframe",
        "alert(",
        "document.cookie"
    };

    localparam logic [POS_W-1:0] SIG_LEN [SIG_COUNT] = '{
        4'd5, 4'd6, 4'd11, 4'd2, 4'd10, 4'd12, 4'd11, 4'd7,
        4'd9, 4'd8, 4'd7, 4'd8, 4'd11, 4'd7, 4'd6, 4'd15
    };

    localparam logic [5:0] SIG_WEIGHT [SIG_COUNT] = '{
        6'd30, 6'd30, 6'd35, 6'd20, 6'd40, 6'd35, 6'd40, 6'd40,
        6'd30, 6'd35, 6'd35, 6'd35, 6'd35, 6'd30, 6'd15, 6'd30
    };

    typedef enum logic [1:0] {
        VERDICT_SAFE       = 2'd0,
        VERDICT_SUSPICIOUS = 2'd1,
        VERDICT_MALICIOUS  = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [SIG_COUNT-1:0] match_mask;
        logic [CNT_W-1:0]     match_count;
        logic [7:0]           threat_score;
        verdict_t             verdict;
    } wsm_result_t;

    // bit i: byte d at distance p from the end agrees with signature i,
    // or signature i is shorter than p+1
    function automatic logic [SIG_COUNT-1:0] sig_hits(input logic [7:0] d,
                                                     input logic [POS_W-1:0] p);
        logic [SIG_COUNT-1:0] h;
        h = '0;
        for (int i = 0; i < SIG_COUNT; i++) begin
            h[i] = (p >= SIG_LEN[i]) || (d == SIG_TEXT[i][{p, 3'b000} +: 8]);
        end
        return h;
    endfunction

endpackage

// ===== sv/wsm_cell.sv =====
// One history cell of the matcher chain: holds a byte, hands it to the next
// cell on a shift and reports which signatures agree at its position. Uses wsm_pkg.
module wsm_cell
    import wsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  logic                 clear,
    input  logic [POS_W-1:0]     pos,
    input  logic [7:0]           data_in,
    output logic [7:0]           data_out,
    output logic [SIG_COUNT-1:0] hits
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (clear) begin
            data_next = '0;
        end else if (shift_en) begin
            data_next = data_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;
    assign hits     = sig_hits(data_reg, pos);

endmodule

// ===== sv/wsm_score.sv =====
// Scoring pipeline: registered mask, group weight sums and counts, then the
// saturated score and verdict in the output register. Uses wsm_pkg.
module wsm_score
    import wsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [SIG_COUNT-1:0] in_mask,
    input  logic [7:0]           score_cap,
    input  logic [7:0]           suspicious_limit,
    output logic                 out_valid,
    output wsm_result_t          result
);

    logic                 v1_reg, v1_next;
    logic                 v2_reg, v2_next;
    logic                 vo_reg, vo_next;
    logic [SIG_COUNT-1:0] mask1_reg, mask1_next;
    logic [SIG_COUNT-1:0] mask2_reg, mask2_next;
    logic [GSUM_W-1:0]    gsum_reg  [GROUPS];
    logic [GSUM_W-1:0]    gsum_next [GROUPS];
    logic [GCNT_W-1:0]    gcnt_reg  [GROUPS];
    logic [GCNT_W-1:0]    gcnt_next [GROUPS];
    wsm_result_t          res_reg, res_next;
    logic [SUM_W-1:0]     total;
    logic [CNT_W-1:0]     count;
    logic [7:0]           score;

    always_comb begin
        v1_next    = v1_reg;
        v2_next    = v2_reg;
        vo_next    = vo_reg;
        mask1_next = mask1_reg;
        mask2_next = mask2_reg;
        for (int g = 0; g < GROUPS; g++) begin
            gsum_next[g] = gsum_reg[g];
            gcnt_next[g] = gcnt_reg[g];
        end
        if (adv) begin
            v1_next    = in_valid;
            mask1_next = in_mask;
            v2_next    = v1_reg;
            mask2_next = mask1_reg;
            vo_next    = v2_reg;
            for (int g = 0; g < GROUPS; g++) begin
                gsum_next[g] = '0;
                gcnt_next[g] = '0;
                for (int k = 0; k < GROUP_SZ; k++) begin
                    if (mask1_reg[g*GROUP_SZ + k]) begin
                        gsum_next[g] = gsum_next[g]
                                     + GSUM_W'(SIG_WEIGHT[g*GROUP_SZ + k]);
                        gcnt_next[g] = gcnt_next[g] + GCNT_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        total = '0;
        count = '0;
        for (int g = 0; g < GROUPS; g++) begin
            total = total + SUM_W'(gsum_reg[g]);
            count = count + CNT_W'(gcnt_reg[g]);
        end
        score = (total > SUM_W'(score_cap)) ? score_cap : total[7:0];
        res_next = res_reg;
        if (adv) begin
            res_next.match_mask   = mask2_reg;
            res_next.match_count  = count;
            res_next.threat_score = score;
            if (score == '0) begin
                res_next.verdict = VERDICT_SAFE;
            end else if (score <= suspicious_limit) begin
                res_next.verdict = VERDICT_SUSPICIOUS;
            end else begin
                res_next.verdict = VERDICT_MALICIOUS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask1_reg <= mask1_next;
        mask2_reg <= mask2_next;
        res_reg   <= res_next;
        for (int g = 0; g < GROUPS; g++) begin
            gsum_reg[g] <= gsum_next[g];
            gcnt_reg[g] <= gcnt_next[g];
        end
    end

    assign out_valid = vo_reg;
    assign result    = res_reg;

endmodule

// ===== sv/weighted_signature_matcher.sv =====
// Top level of the weighted signature matcher: case fold, message state, the
// chain of history cells, config registers and the scoring pipeline.
// Uses wsm_pkg, wsm_cell, wsm_score.
//
//  channel | ports                        | content
//  --------+------------------------------+---------------------------------
//  s_      | s_tvalid s_tready s_tdata    | one message byte, s_tlast = last
//  m_      | m_tvalid m_tready m_tdata    | verdict/score/count/mask per msg
//  cfg_    | cfg_valid cfg_ready          | register index and write data
//
// One byte per cycle while s_tready is high; result via mask/sum/output regs.
// The matching compare is combinational: current byte plus 14 history cells.
// Reset (aresetn low, synchronous) clears message state and loads the
// register defaults. s_tready falls only while a result is held for m_tready.
module weighted_signature_matcher
    import wsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [1:0] verdict, [9:2] threat_score,
                                    // [14:10] match_count, [30:15] match_mask
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic                 adv;
    logic                 take;
    logic                 in_limit;
    logic                 scan;
    logic [7:0]           cur;
    logic [SIG_COUNT-1:0] hits;
    logic [SIG_COUNT-1:0] flags_upd;
    logic [7:0]           chain     [HIST_LEN+1];
    logic [SIG_COUNT-1:0] cell_hits [HIST_LEN];

    logic [SIG_COUNT-1:0] flags_reg, flags_next;
    logic [BYTES_W-1:0]   seen_reg, seen_next;
    logic                 stop_reg, stop_next;
    logic [7:0]           cap_reg, cap_next;
    logic [7:0]           lim_reg, lim_next;

    logic                 out_valid;
    wsm_result_t          result;

    assign adv       = !out_valid || m_tready;
    assign s_tready  = adv;
    assign take      = s_tvalid && adv;
    assign cfg_ready = 1'b1;

    assign in_limit = seen_reg < MAX_BYTES;
    assign scan     = !stop_reg && in_limit && (s_tdata != 8'h00);
    assign cur      = ((s_tdata >= 8'h41) && (s_tdata <= 8'h5A)) ? (s_tdata | 8'h20)
                                                                 : s_tdata;

    assign chain[0] = cur;

    for (genvar j = 0; j < HIST_LEN; j++) begin : g_cell
        wsm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (take && scan),
            .clear    (take && s_tlast),
            .pos      (POS_W'(j + 1)),
            .data_in  (chain[j]),
            .data_out (chain[j+1]),
            .hits     (cell_hits[j])
        );
    end

    always_comb begin
        hits = sig_hits(cur, '0);
        for (int j = 0; j < HIST_LEN; j++) begin
            hits = hits & cell_hits[j];
        end
        flags_upd = scan ? (flags_reg | hits) : flags_reg;
    end

    always_comb begin
        flags_next = flags_reg;
        seen_next  = seen_reg;
        stop_next  = stop_reg;
        if (take) begin
            if (s_tlast) begin
                flags_next = '0;
                seen_next  = '0;
                stop_next  = 1'b0;
            end else begin
                flags_next = flags_upd;
                if (in_limit) begin
                    seen_next = seen_reg + BYTES_W'(1);
                    if (!stop_reg && (s_tdata == 8'h00)) begin
                        stop_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        cap_next = cap_reg;
        lim_next = lim_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCORE_CAP:  cap_next = cfg_data;
                CFG_SUSP_LIMIT: lim_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            seen_reg  <= '0;
            stop_reg  <= 1'b0;
            cap_reg   <= RESET_SCORE_CAP;
            lim_reg   <= RESET_SUSP_LIM;
        end else begin
            flags_reg <= flags_next;
            seen_reg  <= seen_next;
            stop_reg  <= stop_next;
            cap_reg   <= cap_next;
            lim_reg   <= lim_next;
        end
    end

    wsm_score u_score (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .adv              (adv),
        .in_valid         (take && s_tlast),
        .in_mask          (flags_upd),
        .score_cap        (cap_reg),
        .suspicious_limit (lim_reg),
        .out_valid        (out_valid),
        .result           (result)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {1'b0, result};

endmodule
